### rtl/rec_pkg.sv
// shared types and constants for the row entropy block
// depends on nothing; imported by every rtl module of the block
`timescale 1ns / 1ps
`default_nettype none

package rec_pkg;

    localparam int CNT_W       = 24;  // count port width
    localparam int TOT_W       = 29;  // row total width
    localparam int SUM_W       = 48;  // sum of c*ln(c) width
    localparam int LNC_W       = 19;  // ln(c) in q.14
    localparam int LN_W        = 21;  // log unit result width
    localparam int OUT_W       = 20;  // entropy width
    localparam int LG_W        = 29;  // log2 in q5.24
    localparam int LG_FRAC     = 24;
    localparam int MANT_W      = 31;  // mantissa in q1.30
    localparam int NUM_W       = 51;  // divider numerator width
    localparam int PROD_W      = 61;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             last;
    } t_q_entry;

    typedef struct packed {
        logic [OUT_W-1:0] entropy;
        logic             saturated;
    } t_result;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef enum logic [2:0] {
        L_IDLE, L_NORM, L_SQR, L_MUL, L_RND
    } t_log_state;

    typedef enum logic [0:0] {
        D_IDLE, D_RUN
    } t_div_state;

    typedef enum logic [2:0] {
        B_IDLE, B_LOG, B_MUL, B_ACC, B_FIN, B_WAIT, B_OUT
    } t_back_state;

endpackage

`default_nettype wire

### rtl/rec_front.sv
// front end: accepts counts, drops zero counts that end no row, queues the rest
// depends on rec_pkg
`timescale 1ns / 1ps
`default_nettype none

module rec_front #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [rec_pkg::CNT_W-1:0] i_count_value,
    input  wire logic                      i_row_last,
    input  wire logic                      i_pop,
    output rec_pkg::t_q_entry              o_head,
    output logic                           o_head_valid
);
    import rec_pkg::*;

    localparam int EFF_W = (COUNT_WIDTH < CNT_W) ? COUNT_WIDTH : CNT_W;
    localparam logic [CNT_W-1:0] CNT_MASK = CNT_W'((64'd1 << EFF_W) - 64'd1);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    t_q_entry            r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr, r_rd;
    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_W-1:0]    w_count;
    logic                w_push, w_pop;

    assign w_count      = i_count_value & CNT_MASK;
    assign o_ready      = (r_cnt != CNT_BITS'(QUEUE_DEPTH));
    // zero counts change nothing unless they close the row
    assign w_push       = i_valid && o_ready && ((w_count != '0) || i_row_last);
    assign o_head_valid = (r_cnt != '0);
    assign w_pop        = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= '{count: w_count, last: i_row_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_BITS'(w_push) - CNT_BITS'(w_pop);
        end
    end

endmodule

`default_nettype wire

### rtl/rec_log.sv
// iterative natural log: normalize, 24 squaring steps, scale by ln2, round
// depends on rec_pkg
`timescale 1ns / 1ps
`default_nettype none

module rec_log (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_frac_hi,  // 1: q.16, 0: q.14
    input  wire logic [rec_pkg::LG_W-1:0]  i_x,        // nonzero
    output rec_pkg::t_unit_stat            o_stat,
    output logic [rec_pkg::LN_W-1:0]       o_ln
);
    import rec_pkg::*;

    t_log_state          r_state, n_state;
    logic [LG_W-1:0]     r_x;
    logic [4:0]          r_k, r_i;
    logic [MANT_W-1:0]   r_m;
    logic [LG_W-1:0]     r_lg;
    logic [PROD_W-1:0]   r_prod;
    logic [LN_W-1:0]     r_ln;
    logic                r_frac_hi, r_done;
    logic [2*MANT_W-1:0] w_sq;
    logic [MANT_W:0]     w_top;
    logic [PROD_W:0]     w_rnd;

    assign w_sq  = r_m * r_m;
    assign w_top = w_sq[2*MANT_W-1:30];
    assign w_rnd = {1'b0, r_prod} + (r_frac_hi ? (62'd1 << 39) : (62'd1 << 41));

    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE: if (i_start) n_state = L_NORM;
            L_NORM: if (r_x[LG_W-1]) n_state = L_SQR;
            L_SQR:  if (r_i == '0) n_state = L_MUL;
            L_MUL:  n_state = L_RND;
            L_RND:  n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == L_RND);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_x       <= i_x;
                r_k       <= 5'(LG_W - 1);
                r_frac_hi <= i_frac_hi;
            end
            L_NORM: begin
                if (r_x[LG_W-1]) begin
                    r_m  <= {r_x, 2'b00};
                    r_lg <= LG_W'({r_k, 24'd0});
                    r_i  <= 5'(LG_FRAC - 1);
                end else begin
                    r_x <= {r_x[LG_W-2:0], 1'b0};
                    r_k <= r_k - 1'b1;
                end
            end
            L_SQR: begin
                if (w_top[MANT_W]) begin
                    r_lg[r_i] <= 1'b1;
                    r_m       <= w_top[MANT_W:1];
                end else begin
                    r_m <= w_top[MANT_W-1:0];
                end
                r_i <= r_i - 1'b1;
            end
            L_MUL: r_prod <= r_lg * LN2_Q32;
            L_RND: r_ln <= r_frac_hi ? LN_W'(w_rnd >> 40) : LN_W'(w_rnd >> 42);
            default: ;
        endcase
    end

    assign o_stat = '{busy: (r_state != L_IDLE), done: r_done};
    assign o_ln   = r_ln;

endmodule

`default_nettype wire

### rtl/rec_div.sv
// restoring divider, one quotient bit per cycle
// depends on rec_pkg
`timescale 1ns / 1ps
`default_nettype none

module rec_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [rec_pkg::NUM_W-1:0] i_num,
    input  wire logic [rec_pkg::TOT_W-1:0] i_den,
    output rec_pkg::t_unit_stat            o_stat,
    output logic [rec_pkg::NUM_W-1:0]      o_quot
);
    import rec_pkg::*;

    t_div_state       r_state;
    logic [NUM_W-1:0] r_q;
    logic [TOT_W-1:0] r_rem, r_den;
    logic [5:0]       r_n;
    logic             r_done;
    logic [TOT_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: if (i_start) r_state <= D_RUN;
                D_RUN: begin
                    if (r_n == 6'(NUM_W - 1)) begin
                        r_state <= D_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    // quotient holds while idle until the next start
    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE) begin
            if (i_start) begin
                r_q   <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_n   <= '0;
            end
        end else begin
            r_rem <= w_ge ? TOT_W'(w_trial - {1'b0, r_den}) : w_trial[TOT_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], w_ge};
            r_n   <= r_n + 1'b1;
        end
    end

    assign o_stat = '{busy: (r_state != D_IDLE), done: r_done};
    assign o_quot = r_q;

endmodule

`default_nettype wire

### rtl/rec_back.sv
// back end: accumulates row total and sum of c*ln(c), computes the row entropy
// depends on rec_pkg, rec_log, rec_div
`timescale 1ns / 1ps
`default_nettype none

module rec_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  rec_pkg::t_q_entry i_head,
    input  wire logic       i_head_valid,
    output logic            o_pop,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output rec_pkg::t_result o_res
);
    import rec_pkg::*;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    t_back_state        r_state, n_state;
    logic [CNT_W-1:0]   r_c;
    logic               r_last;
    logic [TOT_W-1:0]   r_total;
    logic [SUM_W-1:0]   r_sum;
    logic               r_clamp, r_log_seen, r_div_seen;
    logic [CNT_W+LNC_W-1:0] r_cl;
    t_result            r_res;
    t_unit_stat         w_log_stat, w_div_stat;
    logic [LN_W-1:0]    w_ln;
    logic [NUM_W-1:0]   w_quot;
    logic               w_log_start, w_div_start, w_frac_hi;
    logic [LG_W-1:0]    w_log_x;
    logic [NUM_W-1:0]   w_num;
    logic [TOT_W:0]     w_tsum;
    logic [SUM_W:0]     w_ssum;
    logic [LN_W-1:0]    w_h;

    assign w_frac_hi   = (r_state == B_FIN);
    assign w_log_x     = w_frac_hi ? r_total : LG_W'(i_head.count);
    assign w_log_start = ((r_state == B_IDLE) && i_head_valid && (i_head.count != '0))
                         || ((r_state == B_FIN) && (r_total != '0));
    assign w_div_start = (r_state == B_FIN) && (r_total != '0);
    assign w_num       = {1'b0, r_sum, 2'b00} + NUM_W'(r_total >> 1);
    assign w_tsum      = {1'b0, r_total} + (TOT_W + 1)'(r_c);
    assign w_ssum      = {1'b0, r_sum} + (SUM_W + 1)'(r_cl);
    assign w_h         = w_ln - w_quot[LN_W-1:0];

    rec_log u_log (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_log_start),
        .i_frac_hi (w_frac_hi),
        .i_x       (w_log_x),
        .o_stat    (w_log_stat),
        .o_ln      (w_ln)
    );

    rec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_total),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    assign o_pop = (r_state == B_IDLE) && i_head_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.count != '0) n_state = B_LOG;
                    else if (i_head.last)   n_state = B_FIN;
                end
            end
            B_LOG:  if (w_log_stat.done) n_state = B_MUL;
            B_MUL:  n_state = B_ACC;
            B_ACC:  n_state = r_last ? B_FIN : B_IDLE;
            B_FIN:  n_state = (r_total != '0) ? B_WAIT : B_OUT;
            B_WAIT: begin
                if ((r_log_seen || w_log_stat.done) && (r_div_seen || w_div_stat.done)) begin
                    n_state = B_OUT;
                end
            end
            B_OUT:  if (i_res_ready) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_total <= '0;
            r_sum   <= '0;
            r_clamp <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_ACC) begin
                if (w_tsum[TOT_W]) begin
                    r_total <= '1;
                    r_clamp <= 1'b1;
                end else begin
                    r_total <= w_tsum[TOT_W-1:0];
                end
                if (w_ssum[SUM_W]) begin
                    r_sum   <= '1;
                    r_clamp <= 1'b1;
                end else begin
                    r_sum <= w_ssum[SUM_W-1:0];
                end
            end
            // row delivered: clear accumulators for the next row
            if ((r_state == B_OUT) && i_res_ready) begin
                r_total <= '0;
                r_sum   <= '0;
                r_clamp <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_c    <= i_head.count;
            r_last <= i_head.last;
        end
        if (r_state == B_MUL) begin
            r_cl <= r_c * w_ln[LNC_W-1:0];
        end
        if (r_state == B_FIN) begin
            r_log_seen <= 1'b0;
            r_div_seen <= 1'b0;
            r_res      <= '{entropy: '0, saturated: r_clamp};
        end
        if (r_state == B_WAIT) begin
            if (w_log_stat.done) r_log_seen <= 1'b1;
            if (w_div_stat.done) r_div_seen <= 1'b1;
            if (w_quot >= NUM_W'(w_ln)) begin
                r_res <= '{entropy: '0, saturated: r_clamp};
            end else if (w_h > LN_W'(OUT_MAX)) begin
                r_res <= '{entropy: OUT_MAX, saturated: 1'b1};
            end else begin
                r_res <= '{entropy: w_h[OUT_W-1:0], saturated: r_clamp};
            end
        end
    end

    assign o_res_valid = (r_state == B_OUT);
    assign o_res       = r_res;

endmodule

`default_nettype wire

### rtl/row_entropy_from_counts.sv
// top level of the row entropy block: front queue, back engine, output register
// depends on rec_pkg, rec_front, rec_back
`timescale 1ns / 1ps
`default_nettype none

// Shannon entropy in nats of one row of weighted counts, one count per transfer,
// row_last on the final count; one result transfer per row, unsigned Q4.16, with
// a saturated flag when an accumulator or the result was clamped. Zero counts
// that do not close a row are dropped at the front end, never reach the queue and
// cost nothing else. For a nonzero count c the shared log unit normalizes one bit
// a cycle, then runs 24 squaring steps, a ln2 scale and a round, then the back
// engine multiplies and accumulates. At row end the log of the row total and a
// serial divider run together before the result is shown. A two-entry queue
// lets input transfers continue while the back engine works, and the output
// register lets the next row start while a result waits.

module row_entropy_from_counts #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [rec_pkg::CNT_W-1:0]   i_count_value,
    input  wire logic                        i_row_last,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [rec_pkg::OUT_W-1:0]        o_entropy_nats,
    output logic                             o_saturated
);
    import rec_pkg::*;

    t_q_entry w_head;
    logic     w_head_valid, w_pop;
    logic     w_res_valid, w_res_ready;
    t_result  w_res;
    logic     r_out_valid;
    t_result  r_out;

    // front: transfer in, filter, queue
    rec_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_count_value (i_count_value),
        .i_row_last    (i_row_last),
        .i_pop         (w_pop),
        .o_head        (w_head),
        .o_head_valid  (w_head_valid)
    );

    // back: log, accumulate, divide
    rec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    // output register takes a new result when empty or being drained
    assign w_res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_entropy_nats = r_out.entropy;
    assign o_saturated    = r_out.saturated;

    // a clamped entropy always carries the flag
    a_clamp_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.entropy == '1) |-> r_out.saturated)
        else $error("clamped entropy without saturated flag");

    // back engine holds its result until the output register takes it
    a_back_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && !w_res_ready |=> w_res_valid && $stable(w_res))
        else $error("back result dropped while stalled");

    // back never pops while a result is pending
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !w_pop)
        else $error("queue popped while result pending");

endmodule

`default_nettype wire

### tb/tb_top.sv
// testbench for row_entropy_from_counts: bursty count transfers, stalling result side
// depends on rec_pkg and the rtl of the block; a local entropy predictor checks each row
`timescale 1ns / 1ps

module tb_top;
    import rec_pkg::*;

    localparam int TOTAL_MAX_BITS = 29;
    localparam int LOG_SUM_BITS   = 48;
    localparam int SUM_LN_FRAC    = 14;
    localparam int ENT_FRAC       = 16;
    localparam longint unsigned LN2_SCALE = 64'd2977044472;
    localparam int CYCLE_LIMIT    = 2000000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic             last;
    } t_count_xfer;

    typedef struct {
        logic [OUT_W-1:0] entropy;
        logic             sat;
    } t_entropy_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [CNT_W-1:0] i_count_value = '0;
    logic i_row_last = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [OUT_W-1:0] o_entropy_nats;
    logic o_saturated;

    always #5 i_clk = ~i_clk;

    row_entropy_from_counts u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_count_value  (i_count_value),
        .i_row_last     (i_row_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_entropy_nats (o_entropy_nats),
        .o_saturated    (o_saturated)
    );

    t_count_xfer  pending_counts[$];
    t_entropy_res expected_entropy[$];
    int errors = 0;
    int cycles = 0;

    // predictor state, mirrors the row accumulators
    longint unsigned acc_total = 0;
    longint unsigned acc_clog = 0;
    bit acc_clamped = 0;

    // ln(x) from a 24-fraction-bit log2 by mantissa squaring, scaled by ln2, rounded half up
    function automatic longint unsigned ln_fixed(longint unsigned x, int frac);
        int k;
        longint unsigned m;
        longint unsigned lg;
        int shift;
        if (x == 0) return 0;
        k = 0;
        while (k < 63 && (x >> (k + 1)) != 0) k++;
        m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
        lg = longint'(k) << 24;
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                lg |= (64'd1 << i);
                m >>= 1;
            end
        end
        shift = 32 + 24 - frac;
        return (lg * LN2_SCALE + (64'd1 << (shift - 1))) >> shift;
    endfunction

    // fold one accepted count into the row; push the expected entropy at row end
    task automatic add_count(input logic [CNT_W-1:0] cnt, input logic last);
        longint unsigned c;
        longint unsigned t;
        longint unsigned s;
        longint unsigned lnt;
        longint unsigned q;
        longint unsigned h;
        t_entropy_res r;
        c = cnt;
        if (c != 0) begin
            t = acc_total + c;
            s = acc_clog + c * ln_fixed(c, SUM_LN_FRAC);
            if (t > (64'd1 << TOTAL_MAX_BITS) - 1) begin
                t = (64'd1 << TOTAL_MAX_BITS) - 1;
                acc_clamped = 1;
            end
            if (s > (64'd1 << LOG_SUM_BITS) - 1) begin
                s = (64'd1 << LOG_SUM_BITS) - 1;
                acc_clamped = 1;
            end
            acc_total = t;
            acc_clog = s;
        end
        if (last) begin
            h = 0;
            r.sat = acc_clamped;
            if (acc_total != 0) begin
                lnt = ln_fixed(acc_total, ENT_FRAC);
                q = ((acc_clog << (ENT_FRAC - SUM_LN_FRAC)) + (acc_total >> 1)) / acc_total;
                h = (q >= lnt) ? 0 : lnt - q;
                if (h > (64'd1 << OUT_W) - 1) begin
                    h = (64'd1 << OUT_W) - 1;
                    r.sat = 1;
                end
            end
            r.entropy = h[OUT_W-1:0];
            expected_entropy.push_back(r);
            acc_total = 0;
            acc_clog = 0;
            acc_clamped = 0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // count driver: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) add_count(i_count_value, i_row_last);
            if (i_valid && !o_ready) begin
                // hold the transfer until accepted
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_counts.size() > 0) begin
                t_count_xfer x;
                x = pending_counts.pop_front();
                i_valid <= 1'b1;
                i_count_value <= x.count;
                i_row_last <= x.last;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
                                                           : $urandom_range(0, 6);
                    gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(5, 120)
                                                         : $urandom_range(0, 4);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor with its own stall pattern
    int stall_phase = 0;
    int stall_mode = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_entropy.size() == 0) begin
                    report_mismatch("result with no row pending");
                end else begin
                    t_entropy_res e;
                    e = expected_entropy.pop_front();
                    if (o_entropy_nats !== e.entropy)
                        report_mismatch($sformatf("entropy %0h, predicted %0h",
                                                  o_entropy_nats, e.entropy));
                    if (o_saturated !== e.sat)
                        report_mismatch($sformatf("saturated %0b, predicted %0b",
                                                  o_saturated, e.sat));
                end
            end
            stall_phase = stall_phase + 1;
            if (stall_phase >= 300) begin
                stall_phase = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 3) != 0);
                2:       i_ready <= ((stall_phase % 100) < 60);
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [CNT_W-1:0] random_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return {CNT_W{1'b1}};
            2:       return CNT_W'(1) << $urandom_range(0, CNT_W - 1);
            3, 4:    return CNT_W'($urandom_range(1, 255));
            5, 6:    return CNT_W'($urandom_range(256, 65535));
            default: return CNT_W'($urandom);
        endcase
    endfunction

    task automatic queue_count(input logic [CNT_W-1:0] c, input logic last);
        t_count_xfer x;
        x.count = c;
        x.last = last;
        pending_counts.push_back(x);
    endtask

    initial begin
        int n;
        int len;
        // directed: single counts, extremes, zero rows, uniform and skewed rows
        queue_count(CNT_W'(1), 1'b1);
        queue_count('0, 1'b1);
        queue_count({CNT_W{1'b1}}, 1'b1);
        queue_count('0, 1'b0);
        queue_count('0, 1'b0);
        queue_count('0, 1'b1);
        queue_count(CNT_W'(256), 1'b0);
        queue_count(CNT_W'(256), 1'b1);
        queue_count(CNT_W'(1), 1'b0);
        queue_count({CNT_W{1'b1}}, 1'b1);
        queue_count(CNT_W'(1), 1'b0);
        queue_count('0, 1'b0);
        queue_count(CNT_W'(2), 1'b0);
        queue_count(CNT_W'(3), 1'b1);
        queue_count(CNT_W'(24'h555555), 1'b0);
        queue_count(CNT_W'(24'haaaaaa), 1'b0);
        queue_count(CNT_W'(24'h800000), 1'b1);
        for (int i = 0; i < 4; i++) queue_count(CNT_W'(100), i == 3);
        n = pending_counts.size();
        // random rows, mostly profile length, a few overlong rows of large counts
        while (n < 1800) begin
            if ($urandom_range(0, 24) == 0) begin
                len = $urandom_range(33, 70);
                for (int i = 0; i < len; i++)
                    queue_count($urandom_range(0, 3) == 0 ? CNT_W'($urandom)
                                                          : {CNT_W{1'b1}}, i == len - 1);
            end else begin
                len = $urandom_range(0, 3) == 0 ? $urandom_range(9, 32) : $urandom_range(1, 8);
                for (int i = 0; i < len; i++) queue_count(random_count(), i == len - 1);
            end
            n += len;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_counts.size() > 0 || i_valid || expected_entropy.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
